@@ rtl/plat_pkg.sv @@
package plat_pkg;

  // Operation codes carried in the func field of an input beat.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_MERGED  = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_REMOVED = 2'd3;

  localparam int SYMBOL_W = 64;
  localparam int VALUE_W  = 32;
  localparam int FREED_W  = 7;

  // The freed count sticks at its largest code on very large tables.
  localparam logic [FREED_W-1:0] FREED_MAX = 7'd127;

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic                       func;
    logic [SYMBOL_W-1:0]        symbol;
    logic signed [VALUE_W-1:0]  price;
    logic signed [VALUE_W-1:0]  lot;
  } item_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [VALUE_W-1:0]  level_total;
    logic [FREED_W-1:0]         freed_count;
  } result_t;

  // Classified command handed from the front to the back end.
  typedef struct packed {
    logic                       remove;
    logic [SYMBOL_W-1:0]        symbol;
    logic [VALUE_W-1:0]         price;
    logic [VALUE_W-1:0]         lot;
  } cmd_t;

endpackage

@@ rtl/price_level_aggregation_table_unit.sv @@
// Channel   Handshake             Payload                    Direction
// -------   -------------------   ------------------------   ---------
// item      push / full           plat_pkg::item_t           in
// result    pop / empty           plat_pkg::result_t         out
//
// An insert that matches stops its scan at the matching entry; an insert that
// misses and a remove scan the whole table. The scan is set by the entry memory's
// single read port, which the back end walks one entry per cycle.
// After reset a clearing pass invalidates every entry, and full stays high until
// it ends.
// A four-beat command queue and a result register let each side stall alone.

module price_level_aggregation_table_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int SYMBOL_BITS   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  plat_pkg::item_t     item,
  output logic                empty,
  input  logic                pop,
  output plat_pkg::result_t   result
);

  // The front end accepts a beat whenever its queue has room and no clearing
  // pass runs, decodes the operation and masks the symbol down to the stored
  // width. The back end pulls one command at a time, scans the table memory
  // entry by entry, and parks the finished result in an output register. While
  // that result waits to be popped, new beats keep filling the queue.

  logic            cmd_valid;
  plat_pkg::cmd_t  cmd;
  logic            cmd_take;
  logic            clearing;

  plat_front #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Inserts stop scanning at the first matching level; otherwise the scan
  // covers the whole table, remembering the lowest free entry for a new
  // level, or invalidating each matching level on a remove.
  plat_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SYMBOL_BITS   (SYMBOL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .clearing  (clearing),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ rtl/plat_front.sv @@
module plat_front #(
  parameter int SYMBOL_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  plat_pkg::item_t   item,
  input  logic              clearing,
  output logic              cmd_valid,
  output plat_pkg::cmd_t    cmd,
  input  logic              cmd_take
);

  localparam logic [plat_pkg::SYMBOL_W-1:0] SYM_MASK =
    {plat_pkg::SYMBOL_W{1'b1}} >> (plat_pkg::SYMBOL_W - SYMBOL_BITS);

  plat_pkg::cmd_t                 queue [plat_pkg::QUEUE_DEPTH];
  logic [plat_pkg::QPTR_W-1:0]    wr_ptr;
  logic [plat_pkg::QPTR_W-1:0]    rd_ptr;
  logic [plat_pkg::QCNT_W-1:0]    count;
  plat_pkg::cmd_t                 cmd_in;
  logic                           do_push;
  logic                           do_pop;

  // Decode the operation and drop symbol bits that the table does not keep.
  always_comb begin
    cmd_in.remove = (item.func == plat_pkg::FUNC_REMOVE);
    cmd_in.symbol = item.symbol & SYM_MASK;
    cmd_in.price  = item.price;
    cmd_in.lot    = item.lot;
  end

  assign full      = (count == plat_pkg::QCNT_W'(plat_pkg::QUEUE_DEPTH)) || clearing;
  assign do_push   = push && !full;
  assign cmd_valid = (count != '0);
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + plat_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + plat_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + plat_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - plat_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/plat_back.sv @@
module plat_back #(
  parameter int TABLE_ENTRIES = 64,
  parameter int SYMBOL_BITS   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  plat_pkg::cmd_t      cmd,
  output logic                cmd_take,
  output logic                clearing,
  output logic                empty,
  input  logic                pop,
  output plat_pkg::result_t   result
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  typedef struct packed {
    logic                              valid;
    logic [SYMBOL_BITS-1:0]            symbol;
    logic [plat_pkg::VALUE_W-1:0]      price;
    logic [plat_pkg::VALUE_W-1:0]      total;
  } entry_t;

  entry_t                           mem [TABLE_ENTRIES];
  entry_t                           rd_data;
  entry_t                           wd;
  logic [IDX_W-1:0]                 wa;
  logic                             we;

  logic [2:0]                       state;
  logic [IDX_W-1:0]                 clr_idx;
  logic [CNT_W-1:0]                 scan_cnt;
  logic [IDX_W-1:0]                 eval_idx;
  logic                             rd_pend;
  plat_pkg::cmd_t                   cur;
  logic                             hit;
  logic [IDX_W-1:0]                 hit_idx;
  logic [plat_pkg::VALUE_W-1:0]     hit_total;
  logic                             free_found;
  logic [IDX_W-1:0]                 free_idx;
  logic [plat_pkg::FREED_W-1:0]     freed;
  plat_pkg::result_t                res;
  logic                             out_valid;
  plat_pkg::result_t                out_res;

  logic                             sym_eq;
  logic                             price_eq;
  logic                             hit_now;
  logic                             free_now;
  logic                             rem_now;
  logic                             eval_last;
  logic                             issue;
  logic                             out_load;

  assign sym_eq    = (rd_data.symbol == cur.symbol[SYMBOL_BITS-1:0]);
  assign price_eq  = (rd_data.price == cur.price);
  assign hit_now   = rd_pend && !cur.remove && rd_data.valid && sym_eq && price_eq;
  assign free_now  = rd_pend && !cur.remove && !rd_data.valid && !free_found;
  assign rem_now   = rd_pend && cur.remove && rd_data.valid && sym_eq;
  assign eval_last = rd_pend && (eval_idx == LAST_IDX);
  assign issue     = (state == S_SCAN) && (scan_cnt != CNT_W'(TABLE_ENTRIES)) && !hit_now;
  assign out_load  = (state == S_DONE) && (!out_valid || pop);

  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign clearing  = (state == S_CLEAR);
  assign empty     = !out_valid;
  assign result    = out_res;

  // Single write port: clearing pass, remove invalidation, or the insert update.
  always_comb begin
    we = 1'b0;
    wa = eval_idx;
    wd = rd_data;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_idx;
        wd = '0;
      end
      S_SCAN: begin
        we       = rem_now;
        wa       = eval_idx;
        wd       = rd_data;
        wd.valid = 1'b0;
      end
      S_WRITE: begin
        we        = hit || free_found;
        wa        = hit ? hit_idx : free_idx;
        wd.valid  = 1'b1;
        wd.symbol = cur.symbol[SYMBOL_BITS-1:0];
        wd.price  = cur.price;
        wd.total  = hit ? hit_total : cur.lot;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[scan_cnt[IDX_W-1:0]];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Payload registers of the scan engine.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
    if (issue) begin
      eval_idx <= scan_cnt[IDX_W-1:0];
    end
    if (hit_now) begin
      hit_idx   <= eval_idx;
      hit_total <= rd_data.total + cur.lot;
    end
    if (free_now) begin
      free_idx <= eval_idx;
    end
    if (out_load) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      scan_cnt   <= '0;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      freed      <= '0;
      res        <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_take) begin
            scan_cnt   <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            freed      <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
          if (free_now) begin
            free_found <= 1'b1;
          end
          if (rem_now && (freed != plat_pkg::FREED_MAX)) begin
            freed <= freed + plat_pkg::FREED_W'(1);
          end
          if (hit_now) begin
            hit   <= 1'b1;
            state <= S_WRITE;
          end else if (eval_last) begin
            if (cur.remove) begin
              res.status      <= plat_pkg::ST_REMOVED;
              res.level_total <= '0;
              res.freed_count <= freed + plat_pkg::FREED_W'(rem_now &&
                                 (freed != plat_pkg::FREED_MAX));
              state           <= S_DONE;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          res.freed_count <= '0;
          if (hit) begin
            res.status      <= plat_pkg::ST_MERGED;
            res.level_total <= hit_total;
          end else if (free_found) begin
            res.status      <= plat_pkg::ST_NEW;
            res.level_total <= cur.lot;
          end else begin
            res.status      <= plat_pkg::ST_FULL;
            res.level_total <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rd_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_SCAN))
    else $error("entry read pending outside the scan");

  a_no_write_when_parked: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) || (state == S_DONE)) |-> !we)
    else $error("table written while no command is in progress");

  a_scan_write_only_remove: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && we) |-> cur.remove)
    else $error("insert wrote the table during its scan");

  a_take_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> (state == S_SCAN))
    else $error("accepted command did not start a scan");

  a_full_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.status == plat_pkg::ST_FULL)) |->
      ((out_res.level_total == '0) && (out_res.freed_count == '0)))
    else $error("table-full result carries a nonzero total or count");

endmodule

@@ tb/price_level_aggregation_table_unit_test.sv @@
module price_level_aggregation_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plat_pkg::*;

  // Table geometry used by the block under test and by the predictor alike.
  localparam int LEVELS   = 64;
  localparam int SYM_BITS = 64;
  localparam logic [SYMBOL_W-1:0] SYM_MASK = {SYMBOL_W{1'b1}} >> (SYMBOL_W - SYM_BITS);

  // A miss or a remove walks the whole table, which makes it the slowest beat.
  // Roughly 1400 such beats, plus stalls on both sides, stay far below this
  // limit.
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int TAIL_CYCLES     = LEVELS + 16;
  localparam int ITEMS_PER_PHASE = 440;

  // The scoreboard keeps its own copy of the price-level table. Every accepted
  // input beat is applied to that copy right away, and the result it must
  // produce is queued until the matching output beat comes back.
  class level_book_scoreboard;
    bit                 live     [LEVELS];
    bit [SYMBOL_W-1:0]  sym_of   [LEVELS];
    bit [VALUE_W-1:0]   price_of [LEVELS];
    bit [VALUE_W-1:0]   total_of [LEVELS];
    result_t            awaited_q[$];
    int                 errors;

    function void note_order(item_t it);
      result_t           r;
      bit [SYMBOL_W-1:0] key;
      int                hit;
      int                slot;
      r    = '0;
      key  = it.symbol & SYM_MASK;
      hit  = -1;
      slot = -1;
      if (it.func == FUNC_REMOVE) begin
        for (int i = 0; i < LEVELS; i++) begin
          if (live[i] && sym_of[i] == key) begin
            live[i] = 1'b0;
            if (r.freed_count != FREED_MAX) r.freed_count = r.freed_count + 1'b1;
          end
        end
        r.status = ST_REMOVED;
      end else begin
        // The first matching level wins; a miss takes the lowest free entry.
        for (int i = 0; i < LEVELS; i++) begin
          if (live[i]) begin
            if (hit < 0 && sym_of[i] == key && price_of[i] == it.price) hit = i;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (hit >= 0) begin
          total_of[hit] = total_of[hit] + it.lot;
          r.level_total = total_of[hit];
          r.status      = ST_MERGED;
        end else if (slot >= 0) begin
          live[slot]     = 1'b1;
          sym_of[slot]   = key;
          price_of[slot] = it.price;
          total_of[slot] = it.lot;
          r.level_total  = it.lot;
          r.status       = ST_NEW;
        end else begin
          r.status = ST_FULL;
        end
      end
      awaited_q = {awaited_q, r};
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (awaited_q.size() == 0) begin
        $error("result beat %h arrived with nothing awaited", got);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.level_total !== want.level_total) begin
        $error("level_total: expected %0d, actual %0d", want.level_total, got.level_total);
        errors++;
      end
      if (got.freed_count !== want.freed_count) begin
        $error("freed_count: expected %0d, actual %0d", want.freed_count, got.freed_count);
        errors++;
      end
    endfunction
  endclass

  logic    clk  = 1'b0;
  logic    rst  = 1'b1;
  logic    push = 1'b0;
  logic    full;
  item_t   item = '0;
  logic    empty;
  logic    pop  = 1'b0;
  result_t result;

  level_book_scoreboard book = new();

  // Idle percentages for the two sides; the main sequence changes them per phase.
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int sent_count    = 0;
  int cycle_count   = 0;

  price_level_aggregation_table_unit #(
    .TABLE_ENTRIES(LEVELS),
    .SYMBOL_BITS  (SYM_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always #5 clk = ~clk;

  // Watchdog. A run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side. Values read right after the edge are the ones the block saw at
  // that edge, so a beat counts when pop was high and empty was low there.
  initial begin
    forever begin
      @(posedge clk);
      if (pop && !empty) book.check_report(result);
      pop <= !rst && ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Drives one input beat and returns at the edge that accepted it. Push stays
  // high on return so that back-to-back beats never lower and raise it within
  // one time step; an idle gap lowers it first.
  task automatic send_order(input item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    book.note_order(it);
    sent_count++;
  endtask

  // The sender holds off until every expected result has been taken.
  task automatic hold_until_drained();
    push <= 1'b0;
    do @(posedge clk); while (book.awaited_q.size() != 0);
  endtask

  function automatic item_t make_insert(logic [SYMBOL_W-1:0] sym,
                                        logic [VALUE_W-1:0] price,
                                        logic [VALUE_W-1:0] lot);
    item_t it;
    it.func   = FUNC_INSERT;
    it.symbol = sym;
    it.price  = price;
    it.lot    = lot;
    return it;
  endfunction

  // Price and lot are junk on a remove; the block has to ignore them.
  function automatic item_t make_remove(logic [SYMBOL_W-1:0] sym);
    item_t it;
    it.func   = FUNC_REMOVE;
    it.symbol = sym;
    it.price  = $urandom;
    it.lot    = $urandom;
    return it;
  endfunction

  // Short upper-case tickers packed into the low bytes half the time, otherwise a
  // fully random code so that every symbol bit toggles.
  function automatic logic [SYMBOL_W-1:0] random_symbol();
    logic [SYMBOL_W-1:0] s;
    int                  n;
    s = '0;
    if ($urandom_range(1) == 0) begin
      n = $urandom_range(1, 8);
      for (int c = 0; c < n; c++) s[c*8 +: 8] = 8'($urandom_range(65, 90));
    end else begin
      s = {$urandom, $urandom};
    end
    return s;
  endfunction

  // Prices and lots: half of them small, the rest full-range values and values close to
  // both ends of the signed range so that totals wrap.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(7))
      0, 1:    v = $urandom;
      2:       v = 32'h7FFF_FFFF - $urandom_range(3);
      3:       v = 32'h8000_0000 + $urandom_range(3);
      default: v = $urandom_range(2000) - 1000;
    endcase
    return v;
  endfunction

  // Hand-picked beats: both ends of every field, both operations, a remove of
  // an absent symbol, merges that wrap past either end, reuse of a freed
  // entry, and symbols that differ from each other in one bit only.
  task automatic run_directed();
    logic [SYMBOL_W-1:0] zero_sym;
    logic [SYMBOL_W-1:0] ones_sym;
    logic [SYMBOL_W-1:0] top_sym;
    zero_sym = '0;
    ones_sym = '1;
    top_sym  = {1'b1, {(SYMBOL_W-1){1'b0}}};
    send_order(make_remove(ones_sym));
    send_order(make_insert(zero_sym, 32'sd0, 32'sd0));
    send_order(make_insert(ones_sym, 32'h8000_0000, 32'h7FFF_FFFF));
    send_order(make_insert(ones_sym, 32'h8000_0000, 32'sd1));
    send_order(make_insert(ones_sym, 32'h7FFF_FFFF, 32'h8000_0000));
    send_order(make_insert(ones_sym, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_order(make_insert(zero_sym, 32'sd0, 32'h8000_0000));
    send_order(make_insert(zero_sym, 32'sd0, 32'h8000_0000));
    send_order(make_insert(zero_sym, 32'h7FFF_FFFF, 32'sd5));
    send_order(make_insert(top_sym, 32'sd0, 32'sd9));
    send_order(make_insert(64'h0000_4142_4344_4546, 32'sd100, 32'sd1));
    send_order(make_remove(ones_sym));
    send_order(make_insert(ones_sym, 32'h8000_0000, 32'sd7));
    send_order(make_remove(zero_sym));
    send_order(make_remove(zero_sym));
    send_order(make_remove(top_sym));
    send_order(make_remove(ones_sym));
    send_order(make_remove(64'h0000_4142_4344_4546));
  endtask

  // One symbol claims more levels than the table holds, with a few merges in
  // between, so the last inserts find the table full. The remove then frees
  // every level at once.
  task automatic run_fill_episode();
    logic [SYMBOL_W-1:0] sym;
    logic [VALUE_W-1:0]  base;
    sym  = random_symbol();
    base = random_value();
    for (int k = 0; k < LEVELS + 4; k++) begin
      send_order(make_insert(sym, base + k, random_value()));
      if (k % 16 == 15) send_order(make_insert(sym, base + $urandom_range(k), random_value()));
    end
    send_order(make_remove(sym));
  endtask

  // A small market: a few symbols, some of them one bit apart, and a band of
  // prices, so inserts hit existing levels often. Removes come now and then,
  // and every symbol is cleared at the end so the next episode starts empty.
  task automatic run_trading_episode();
    logic [SYMBOL_W-1:0] pool [4];
    logic [VALUE_W-1:0]  base;
    int                  n_sym;
    int                  n_price;
    int                  len;
    n_sym   = $urandom_range(1, 4);
    n_price = $urandom_range(1, 24);
    len     = $urandom_range(10, 60);
    base    = random_value();
    pool[0] = random_symbol();
    for (int k = 1; k < 4; k++) begin
      if ($urandom_range(2) == 0) pool[k] = pool[0] ^ (64'd1 << $urandom_range(SYMBOL_W - 1));
      else pool[k] = random_symbol();
    end
    repeat (len) begin
      if ($urandom_range(99) < 8) begin
        send_order(make_remove(pool[$urandom_range(n_sym - 1)]));
      end else begin
        send_order(make_insert(pool[$urandom_range(n_sym - 1)],
                               base + $urandom_range(n_price - 1), random_value()));
      end
    end
    for (int k = 0; k < n_sym; k++) send_order(make_remove(pool[k]));
  endtask

  // Unstructured beats with every field random, followed by removes of what
  // they inserted. Each of those removes frees the level that its insert made.
  task automatic run_noise_episode();
    item_t               it;
    logic [SYMBOL_W-1:0] touched[$];
    repeat ($urandom_range(4, 16)) begin
      it.func   = 1'($urandom_range(1));
      it.symbol = {$urandom, $urandom};
      it.price  = $urandom;
      it.lot    = $urandom;
      if (it.func == FUNC_INSERT) touched = {touched, it.symbol};
      send_order(it);
    end
    foreach (touched[k]) send_order(make_remove(touched[k]));
  endtask

  // Main sequence. Reset is held at the start; the clearing pass that follows
  // keeps full high, and send_order simply waits it out. Three phases
  // of random traffic follow the directed beats: a slow receiver first, then a
  // slow sender, then neither side idles. Between phases the sender drains
  // the block completely, which also exercises a long pause on the input side.
  initial begin
    int phase_start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 13;
    take_idle_pct = 59;
    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      hold_until_drained();
      case (phase)
        0: begin
          send_idle_pct = 13;
          take_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          take_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      phase_start = sent_count;
      run_fill_episode();
      while (sent_count - phase_start < ITEMS_PER_PHASE) begin
        case ($urandom_range(99)) inside
          [0:14]:  run_fill_episode();
          [15:34]: run_noise_episode();
          default: run_trading_episode();
        endcase
      end
    end
    // Let the last results come back, then give the block time to show any
    // stray beat it should not produce.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.awaited_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/plat_pkg.sv
rtl/plat_front.sv
rtl/plat_back.sv
rtl/price_level_aggregation_table_unit.sv
tb/price_level_aggregation_table_unit_test.sv
